@@ hw/rtl/cna_pkg.sv @@
`default_nettype none
package cna_pkg;

	// default operand format: signed Q16.16
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	// compare tolerance register
	localparam int              TOL_W     = 16;
	localparam logic [TOL_W-1:0] TOL_RESET = 16'd655;

	typedef enum logic [2:0] {
		MODE_ADD  = 3'd0,
		MODE_SUB  = 3'd1,
		MODE_MUL  = 3'd2,
		MODE_CDIV = 3'd3,
		MODE_RDIV = 3'd4,
		MODE_CMP  = 3'd5
	} mode_t;

endpackage
`default_nettype wire

@@ hw/rtl/cna_sat.sv @@
`default_nettype none
// Clamp a sign/magnitude value to the signed DW-bit range.
module cna_sat #(
	parameter int DW = 32,
	parameter int MW = 64
) (
	input  logic                 neg,
	input  logic [MW-1:0]        mag,
	input  logic                 big,
	output logic signed [DW-1:0] val,
	output logic                 ovf
);

	localparam logic [MW-1:0] LIM   = MW'(1) << (DW-1);
	localparam logic [MW-1:0] LIMM1 = LIM - MW'(1);

	// negative side reaches one step further than the positive side
	always_comb begin
		if (neg) begin
			ovf = big || (mag > LIM);
			val = ovf ? LIM[DW-1:0] : -mag[DW-1:0];
		end else begin
			ovf = big || (mag > LIMM1);
			val = ovf ? LIMM1[DW-1:0] : mag[DW-1:0];
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/cna_div.sv @@
`default_nettype none
// Pipelined restoring divider: floor((num << FW) / den), one quotient bit per stage.
// big is set when the quotient does not fit in DW+1 bits (or den is zero).
module cna_div #(
	parameter int DW = 32,
	parameter int FW = 16
) (
	input  logic            clk,
	input  logic            en,
	input  logic [2*DW-1:0] num,
	input  logic [2*DW-1:0] den,
	output logic [DW:0]     quo,
	output logic            big
);

	localparam int PW = 2*DW;
	localparam int QW = DW+1;
	localparam int NW = PW+FW;
	localparam int HW = NW-QW;
	localparam int CW = (HW > PW) ? HW : PW;
	localparam int RW = PW+1;

	logic [NW-1:0] nfull;
	logic [HW-1:0] hi;
	logic          big0;

	logic [RW-1:0] rem_s5 [0:QW-1];
	logic [QW-1:0] lo_s5  [0:QW-1];
	logic [PW-1:0] den_s5 [0:QW-1];
	logic [QW-1:0] quo_s5 [1:QW];
	logic          big_s5 [0:QW];

	// top part of the dividend is the starting remainder
	assign nfull = {num, {FW{1'b0}}};
	assign hi    = nfull[NW-1:QW];
	assign big0  = CW'(hi) >= CW'(den);

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s5[0] <= RW'(hi);
			lo_s5[0]  <= nfull[QW-1:0];
			den_s5[0] <= den;
			big_s5[0] <= big0;
		end
	end

	// one trial subtract per stage
	for (genvar k = 1; k <= QW; k++) begin : g_step
		logic [RW-1:0] r2;
		logic          ge;

		assign r2   = {rem_s5[k-1][RW-2:0], lo_s5[k-1][QW-1]};
		assign ge   = r2 >= {1'b0, den_s5[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				big_s5[k] <= big_s5[k-1];
			end
		end

		if (k == 1) begin : g_first
			always_ff @(posedge clk) begin
				if (en) begin
					quo_s5[k] <= QW'(ge);
				end
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en) begin
					quo_s5[k] <= {quo_s5[k-1][QW-2:0], ge};
				end
			end
		end

		if (k < QW) begin : g_carry
			logic [RW-1:0] diff;

			assign diff = r2 - {1'b0, den_s5[k-1]};

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s5[k] <= ge ? diff : r2;
					lo_s5[k]  <= lo_s5[k-1] << 1;
					den_s5[k] <= den_s5[k-1];
				end
			end
		end
	end

	assign quo = quo_s5[QW];
	assign big = big_s5[QW];

endmodule
`default_nettype wire

@@ hw/rtl/complex_number_alu.sv @@
// Complex arithmetic unit, signed fixed point (Q16.16 by default).
// Throughput: one item per cycle while the output skid is empty; the divider takes one quotient bit per stage
// over DATA_WIDTH+1 stages, all modes share that pipeline depth.
// Reset (arst_n low): valid bits and skid flag clear, tolerance returns to 655.
`default_nettype none
module complex_number_alu
	import cna_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [TOL_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [2:0]       mode,
	input  logic [31:0]      a_re,
	input  logic [31:0]      a_im,
	input  logic [31:0]      b_re,
	input  logic [31:0]      b_im,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      result_re,
	output logic [31:0]      result_im,
	output logic             divide_by_zero,
	output logic             overflowed,
	output logic             is_equal
);

	localparam int DW = DATA_WIDTH;
	localparam int FW = FRAC_BITS;
	localparam int PW = 2*DW;
	localparam int SW = PW+1;
	localparam int AW = DW+1;
	localparam int QW = DW+1;
	localparam int TW = ((AW > TOL_W+1) ? AW : TOL_W+1) + 1;

	localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};

	typedef struct packed {
		mode_t                mode;
		logic                 dbz;
		logic                 ovf;
		logic                 eq;
		logic                 neg_re;
		logic                 neg_im;
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
	} side_t;

	typedef struct packed {
		logic signed [DW-1:0] re;
		logic signed [DW-1:0] im;
		logic                 dbz;
		logic                 ovf;
		logic                 eq;
	} res_t;

	// {overflow, value} of a DW+1 bit sum clipped to DW bits
	function automatic logic [DW:0] clip_sum(input logic signed [AW-1:0] d);
		logic o;
		o = d[AW-1] ^ d[AW-2];
		if (!o) return {1'b0, d[DW-1:0]};
		else if (d[AW-1]) return {1'b1, SMIN};
		else return {1'b1, SMAX};
	endfunction

	// |d| <= t
	function automatic logic near_f(input logic signed [AW-1:0] d,
			input logic [TOL_W-1:0] t);
		logic signed [TW-1:0] dx;
		logic signed [TW-1:0] tx;
		dx = TW'(d);
		tx = $signed(TW'(t));
		return (dx <= tx) && (dx >= -tx);
	endfunction

	function automatic logic [PW-1:0] mag_of(input logic signed [SW-1:0] v);
		logic signed [SW-1:0] n;
		n = -v;
		return v[SW-1] ? n[PW-1:0] : v[PW-1:0];
	endfunction

	logic en;
	logic [TOL_W-1:0] equal_tolerance_q;

	// tolerance register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			equal_tolerance_q <= TOL_RESET;
		end else if (cfg_wr_en) begin
			equal_tolerance_q <= cfg_wr_data;
		end
	end

	// ---------------- valid line ----------------
	logic          v_s1, v_s2, v_s3, v_s4, v_s6;
	logic [QW:0]   v_s5;
	logic          skid_vld_q;

	assign en       = !skid_vld_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= '0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= {v_s5[QW-1:0], v_s4};
			v_s6 <= v_s5[QW];
		end
	end

	// ---------------- s1: operand capture ----------------
	mode_t                mode_s1;
	logic signed [DW-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1 <= mode_t'(mode);
			ar_s1   <= a_re[DW-1:0];
			ai_s1   <= a_im[DW-1:0];
			br_s1   <= b_re[DW-1:0];
			bi_s1   <= b_im[DW-1:0];
		end
	end

	// ---------------- s2: products, sums, magnitudes ----------------
	mode_t                mode_s2;
	logic signed [PW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2, p_br2_s2, p_bi2_s2;
	logic signed [AW-1:0] d_re_s2, d_im_s2;
	logic [DW-1:0]        abs_ar_s2, abs_ai_s2, abs_br_s2;
	logic                 neg_ar_s2, neg_ai_s2, neg_br_s2, br_zero_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s2    <= mode_s1;
			p_rr_s2    <= PW'(ar_s1) * PW'(br_s1);
			p_ii_s2    <= PW'(ai_s1) * PW'(bi_s1);
			p_ri_s2    <= PW'(ar_s1) * PW'(bi_s1);
			p_ir_s2    <= PW'(ai_s1) * PW'(br_s1);
			p_br2_s2   <= PW'(br_s1) * PW'(br_s1);
			p_bi2_s2   <= PW'(bi_s1) * PW'(bi_s1);
			d_re_s2    <= (mode_s1 == MODE_ADD) ? AW'(ar_s1) + AW'(br_s1)
				: AW'(ar_s1) - AW'(br_s1);
			d_im_s2    <= (mode_s1 == MODE_ADD) ? AW'(ai_s1) + AW'(bi_s1)
				: AW'(ai_s1) - AW'(bi_s1);
			abs_ar_s2  <= ar_s1[DW-1] ? -ar_s1 : ar_s1;
			abs_ai_s2  <= ai_s1[DW-1] ? -ai_s1 : ai_s1;
			abs_br_s2  <= br_s1[DW-1] ? -br_s1 : br_s1;
			neg_ar_s2  <= ar_s1[DW-1];
			neg_ai_s2  <= ai_s1[DW-1];
			neg_br_s2  <= br_s1[DW-1];
			br_zero_s2 <= (br_s1 == '0);
		end
	end

	// ---------------- s3: cross sums, add/sub/compare results ----------------
	logic signed [DW-1:0] sre, sim;
	logic                 sovf, seq, ovf_r, ovf_i;

	always_comb begin
		sre  = '0;
		sim  = '0;
		sovf = 1'b0;
		seq  = 1'b0;
		ovf_r = 1'b0;
		ovf_i = 1'b0;
		case (mode_s2)
			MODE_ADD, MODE_SUB: begin
				{ovf_r, sre} = clip_sum(d_re_s2);
				{ovf_i, sim} = clip_sum(d_im_s2);
				sovf = ovf_r | ovf_i;
			end
			MODE_CMP: begin
				seq = near_f(d_re_s2, equal_tolerance_q) && near_f(d_im_s2, equal_tolerance_q);
			end
			default: begin
			end
		endcase
	end

	mode_t                mode_s3;
	logic signed [SW-1:0] mr_s3, mi_s3, dr_s3, di_s3;
	logic [PW-1:0]        den_s3;
	logic [DW-1:0]        abs_ar_s3, abs_ai_s3, abs_br_s3;
	logic                 neg_ar_s3, neg_ai_s3, neg_br_s3, br_zero_s3;
	logic signed [DW-1:0] sre_s3, sim_s3;
	logic                 sovf_s3, seq_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s3    <= mode_s2;
			mr_s3      <= SW'(p_rr_s2) - SW'(p_ii_s2);
			mi_s3      <= SW'(p_ri_s2) + SW'(p_ir_s2);
			dr_s3      <= SW'(p_rr_s2) + SW'(p_ii_s2);
			di_s3      <= SW'(p_ir_s2) - SW'(p_ri_s2);
			den_s3     <= $unsigned(p_br2_s2) + $unsigned(p_bi2_s2);
			abs_ar_s3  <= abs_ar_s2;
			abs_ai_s3  <= abs_ai_s2;
			abs_br_s3  <= abs_br_s2;
			neg_ar_s3  <= neg_ar_s2;
			neg_ai_s3  <= neg_ai_s2;
			neg_br_s3  <= neg_br_s2;
			br_zero_s3 <= br_zero_s2;
			sre_s3     <= sre;
			sim_s3     <= sim;
			sovf_s3    <= sovf;
			seq_s3     <= seq;
		end
	end

	// ---------------- s4: magnitudes and divider operands ----------------
	logic [PW-1:0] num_re, num_im, den;
	logic          neg_re, neg_im, dbz;

	always_comb begin
		num_re = mag_of(mr_s3);
		num_im = mag_of(mi_s3);
		neg_re = mr_s3[SW-1];
		neg_im = mi_s3[SW-1];
		den    = den_s3;
		dbz    = 1'b0;
		case (mode_s3)
			MODE_CDIV: begin
				num_re = mag_of(dr_s3);
				num_im = mag_of(di_s3);
				neg_re = dr_s3[SW-1];
				neg_im = di_s3[SW-1];
				dbz    = (den_s3 == '0);
			end
			MODE_RDIV: begin
				num_re = PW'(abs_ar_s3);
				num_im = PW'(abs_ai_s3);
				den    = PW'(abs_br_s3);
				neg_re = neg_ar_s3 ^ neg_br_s3;
				neg_im = neg_ai_s3 ^ neg_br_s3;
				dbz    = br_zero_s3;
			end
			default: begin
			end
		endcase
	end

	mode_t                mode_s4;
	logic [PW-1:0]        num_re_s4, num_im_s4, den_s4;
	logic                 neg_re_s4, neg_im_s4, dbz_s4;
	logic signed [DW-1:0] sre_s4, sim_s4;
	logic                 sovf_s4, seq_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s4   <= mode_s3;
			num_re_s4 <= num_re;
			num_im_s4 <= num_im;
			den_s4    <= den;
			neg_re_s4 <= neg_re;
			neg_im_s4 <= neg_im;
			dbz_s4    <= dbz;
			sre_s4    <= sre_s3;
			sim_s4    <= sim_s3;
			sovf_s4   <= sovf_s3;
			seq_s4    <= seq_s3;
		end
	end

	// ---------------- multiply result: drop fraction bits, clamp ----------------
	logic [PW-1:0]        mul_mag_re, mul_mag_im;
	logic signed [DW-1:0] mul_re, mul_im;
	logic                 mul_ovf_re, mul_ovf_im;

	assign mul_mag_re = num_re_s4 >> FW;
	assign mul_mag_im = num_im_s4 >> FW;

	cna_sat #(.DW(DW), .MW(PW)) u_mul_sat_re (
		.neg (neg_re_s4),
		.mag (mul_mag_re),
		.big (1'b0),
		.val (mul_re),
		.ovf (mul_ovf_re)
	);

	cna_sat #(.DW(DW), .MW(PW)) u_mul_sat_im (
		.neg (neg_im_s4),
		.mag (mul_mag_im),
		.big (1'b0),
		.val (mul_im),
		.ovf (mul_ovf_im)
	);

	// ---------------- s5: divider and matching side line ----------------
	side_t side_in;
	side_t side_s5 [0:QW];

	always_comb begin
		side_in.mode   = mode_s4;
		side_in.dbz    = dbz_s4;
		side_in.eq     = seq_s4;
		side_in.neg_re = neg_re_s4;
		side_in.neg_im = neg_im_s4;
		if (mode_s4 == MODE_MUL) begin
			side_in.re  = mul_re;
			side_in.im  = mul_im;
			side_in.ovf = mul_ovf_re | mul_ovf_im;
		end else begin
			side_in.re  = sre_s4;
			side_in.im  = sim_s4;
			side_in.ovf = sovf_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5[0] <= side_in;
			for (int k = 1; k <= QW; k++) begin
				side_s5[k] <= side_s5[k-1];
			end
		end
	end

	logic [QW-1:0] quo_re, quo_im;
	logic          big_re, big_im;

	cna_div #(.DW(DW), .FW(FW)) u_div_re (
		.clk (clk),
		.en  (en),
		.num (num_re_s4),
		.den (den_s4),
		.quo (quo_re),
		.big (big_re)
	);

	cna_div #(.DW(DW), .FW(FW)) u_div_im (
		.clk (clk),
		.en  (en),
		.num (num_im_s4),
		.den (den_s4),
		.quo (quo_im),
		.big (big_im)
	);

	logic signed [DW-1:0] div_re, div_im;
	logic                 div_ovf_re, div_ovf_im;

	cna_sat #(.DW(DW), .MW(QW)) u_div_sat_re (
		.neg (side_s5[QW].neg_re),
		.mag (quo_re),
		.big (big_re),
		.val (div_re),
		.ovf (div_ovf_re)
	);

	cna_sat #(.DW(DW), .MW(QW)) u_div_sat_im (
		.neg (side_s5[QW].neg_im),
		.mag (quo_im),
		.big (big_im),
		.val (div_im),
		.ovf (div_ovf_im)
	);

	// ---------------- s6: result select ----------------
	res_t res_nx;
	res_t res_s6;

	always_comb begin
		res_nx    = '0;
		res_nx.eq = side_s5[QW].eq;
		case (side_s5[QW].mode)
			MODE_CDIV, MODE_RDIV: begin
				if (side_s5[QW].dbz) begin
					res_nx.dbz = 1'b1;
				end else begin
					res_nx.re  = div_re;
					res_nx.im  = div_im;
					res_nx.ovf = div_ovf_re | div_ovf_im;
				end
			end
			default: begin
				res_nx.re  = side_s5[QW].re;
				res_nx.im  = side_s5[QW].im;
				res_nx.ovf = side_s5[QW].ovf;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s6 <= res_nx;
		end
	end

	// ---------------- output skid ----------------
	res_t skid_q;
	res_t out_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (out_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (v_s6 && !out_ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			skid_q <= res_s6;
		end
	end

	assign out_r          = skid_vld_q ? skid_q : res_s6;
	assign out_valid      = skid_vld_q | v_s6;
	assign result_re      = 32'(out_r.re);
	assign result_im      = 32'(out_r.im);
	assign divide_by_zero = out_r.dbz;
	assign overflowed     = out_r.ovf;
	assign is_equal       = out_r.eq;

`ifndef SYNTHESIS
	// an equal compare carries no arithmetic result or flags
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_equal |-> result_re == '0 && result_im == '0
			&& !overflowed && !divide_by_zero)
		else $error("compare item with arithmetic result");

	// zero divisor gives zero parts and no overflow
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> result_re == '0 && result_im == '0
			&& !overflowed && !is_equal)
		else $error("divide by zero with nonzero result");

	// skid fills only from a stalled finished item
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(v_s6 && !out_ready))
		else $error("skid filled without stalled item");

	// a stall freezes the valid line
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(v_s5))
		else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import cna_pkg::*;

	localparam int LATENCY = 38;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [2:0]  mode;
		logic [31:0] a_re;
		logic [31:0] a_im;
		logic [31:0] b_re;
		logic [31:0] b_im;
	} operands_t;

	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
		logic        dbz;
		logic        ovf;
		logic        eq;
	} alu_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [TOL_W-1:0] cfg_wr_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] mode = '0;
	logic [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [31:0] result_re, result_im;
	logic divide_by_zero, overflowed, is_equal;

	operands_t   pending_q[$];
	alu_result_t expected_q[$];
	logic [15:0] tolerance = TOL_RESET;
	int errors = 0;
	int cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;

	complex_number_alu dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
		.out_valid(out_valid), .out_ready(out_ready),
		.result_re(result_re), .result_im(result_im),
		.divide_by_zero(divide_by_zero), .overflowed(overflowed),
		.is_equal(is_equal)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// saturate sign/magnitude into 32-bit signed range
	function automatic logic [31:0] saturate(input logic neg, input logic [127:0] m,
			inout logic ovf);
		if (neg) begin
			if (m > 128'h8000_0000) begin
				ovf = 1'b1;
				return 32'h8000_0000;
			end
			return 32'(-m);
		end
		if (m > 128'h7FFF_FFFF) begin
			ovf = 1'b1;
			return 32'h7FFF_FFFF;
		end
		return m[31:0];
	endfunction

	function automatic logic [127:0] magnitude(input logic signed [127:0] v);
		return v < 0 ? -v : v;
	endfunction

	// exact value, truncated toward zero after scaling by 2^16 / den
	function automatic logic [31:0] scaled_quotient(input logic signed [127:0] num,
			input logic [127:0] den, inout logic ovf);
		logic [127:0] q;
		q = (magnitude(num) << 16) / den;
		return saturate(num < 0 && q != 0, q, ovf);
	endfunction

	function automatic alu_result_t compute_result(input operands_t op);
		alu_result_t r;
		logic signed [127:0] ar, ai, br, bi, x, y;
		logic [127:0] den;
		r = '0;
		ar = signed'(op.a_re);
		ai = signed'(op.a_im);
		br = signed'(op.b_re);
		bi = signed'(op.b_im);
		case (op.mode)
			MODE_ADD: begin
				r.re = saturate(ar + br < 0, magnitude(ar + br), r.ovf);
				r.im = saturate(ai + bi < 0, magnitude(ai + bi), r.ovf);
			end
			MODE_SUB: begin
				r.re = saturate(ar - br < 0, magnitude(ar - br), r.ovf);
				r.im = saturate(ai - bi < 0, magnitude(ai - bi), r.ovf);
			end
			MODE_MUL: begin
				x = ar * br - ai * bi;
				y = ar * bi + ai * br;
				r.re = saturate(x < 0 && (magnitude(x) >> 16) != 0,
					magnitude(x) >> 16, r.ovf);
				r.im = saturate(y < 0 && (magnitude(y) >> 16) != 0,
					magnitude(y) >> 16, r.ovf);
			end
			MODE_CDIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.dbz = 1'b1;
				end else begin
					r.re = scaled_quotient(ar * br + ai * bi, den, r.ovf);
					r.im = scaled_quotient(ai * br - ar * bi, den, r.ovf);
				end
			end
			MODE_RDIV: begin
				if (br == 0) begin
					r.dbz = 1'b1;
				end else begin
					r.re = scaled_quotient(br < 0 ? -ar : ar, magnitude(br), r.ovf);
					r.im = scaled_quotient(br < 0 ? -ai : ai, magnitude(br), r.ovf);
				end
			end
			MODE_CMP: begin
				r.eq = magnitude(ar - br) <= tolerance && magnitude(ai - bi) <= tolerance;
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] random_part();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'(signed'($urandom_range(0, 2 ** 20)) - 2 ** 19);
			3: return 32'(signed'($urandom_range(0, 2 ** 24)) - 2 ** 23);
			4: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic operands_t random_item();
		operands_t op;
		op.mode = $urandom_range(0, 15) == 0 ? 3'($urandom_range(6, 7))
			: 3'($urandom_range(0, 5));
		op.a_re = random_part();
		op.a_im = random_part();
		op.b_re = random_part();
		op.b_im = random_part();
		// compare items near each other so the tolerance matters
		if (op.mode == MODE_CMP && $urandom_range(0, 2) != 0) begin
			op.b_re = op.a_re + 32'($urandom_range(0, 1400)) - 32'd700;
			op.b_im = op.a_im + 32'($urandom_range(0, 1400)) - 32'd700;
		end
		return op;
	endfunction

	function automatic int random_gap();
		int g;
		g = $urandom_range(0, 19);
		if (g < 12) return 0;
		if (g < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h expected %h", field, got, want);
		errors++;
	endtask

	// driver: present items from the pending queue, hold until accepted
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_q.push_back(compute_result({mode, a_re, a_im, b_re, b_im}));
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0 || pending_q.size() == 0) begin
					in_valid <= 1'b0;
					if (send_gap > 0) send_gap <= send_gap - 1;
				end else begin
					operands_t op;
					op = pending_q.pop_front();
					in_valid <= 1'b1;
					{mode, a_re, a_im, b_re, b_im} <= op;
					send_gap <= random_gap();
				end
			end
			if (recv_gap > 0) begin
				out_ready <= 1'b0;
				recv_gap <= recv_gap - 1;
			end else begin
				out_ready <= 1'b1;
				recv_gap <= random_gap();
			end
		end
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$display("unexpected result %h %h", result_re, result_im);
				errors++;
			end else begin
				alu_result_t w;
				w = expected_q.pop_front();
				if (result_re !== w.re) report_mismatch("result_re", result_re, w.re);
				if (result_im !== w.im) report_mismatch("result_im", result_im, w.im);
				if (divide_by_zero !== w.dbz)
					report_mismatch("divide_by_zero", 32'(divide_by_zero), 32'(w.dbz));
				if (overflowed !== w.ovf)
					report_mismatch("overflowed", 32'(overflowed), 32'(w.ovf));
				if (is_equal !== w.eq)
					report_mismatch("is_equal", 32'(is_equal), 32'(w.eq));
			end
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout");
			$display("tb: failure");
			$finish;
		end
	end

	task automatic push(input logic [2:0] m, input logic [31:0] ar, input logic [31:0] ai,
			input logic [31:0] br, input logic [31:0] bi);
		pending_q.push_back({m, ar, ai, br, bi});
	endtask

	// check at the falling edge so the driver's updates have settled
	task automatic drain();
		while (pending_q.size() != 0 || in_valid || expected_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_tolerance(input logic [15:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tolerance = v;
		@(posedge clk);
	endtask

	initial begin
		logic [15:0] tol_set[4];
		tol_set = '{16'd0, 16'd65535, 16'd1, 16'd655};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every mode, zero divisors, saturation, tolerance edges
		push(MODE_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'hFFFF_FFFF);
		push(MODE_ADD, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0);
		push(MODE_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF);
		push(MODE_SUB, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
		push(MODE_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		push(MODE_MUL, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_8000, 32'h0001_0000);
		push(MODE_MUL, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h0);
		push(MODE_CDIV, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
		push(MODE_CDIV, 32'h0003_0000, 32'h0004_0000, 32'h0001_0000, 32'hFFFF_0000);
		push(MODE_CDIV, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 32'h0);
		push(MODE_CDIV, 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000);
		push(MODE_RDIV, 32'h0005_0000, 32'h0, 32'h0, 32'h1234_5678);
		push(MODE_RDIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		push(MODE_RDIV, 32'hFFFF_FFFF, 32'h0007_0000, 32'h0003_0000, 32'h5);
		push(MODE_CMP, 32'h0001_0000, 32'h0, 32'h0001_028F, 32'hFFFF_FD71);
		push(MODE_CMP, 32'h0001_0000, 32'h0, 32'h0001_0290, 32'h0);
		push(MODE_CMP, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0);
		push(3'd6, 32'hFFFF_FFFF, 32'h1, 32'h2, 32'h3);
		push(3'd7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0);
		drain();

		// random phases across tolerance settings
		foreach (tol_set[p]) begin
			write_tolerance(tol_set[p]);
			repeat (320) pending_q.push_back(random_item());
			push(MODE_CMP, 32'h0, 32'h0, 32'(tol_set[p]), 32'h0);
			push(MODE_CMP, 32'h0, 32'h0, 32'(tol_set[p]) + 32'd1, 32'h0);
			drain();
		end

		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
`default_nettype wire
